FILE: sv/assert_macros.svh
// Assertion macros used by the checker of the allocator.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is applied.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`endif

FILE: sv/hba3_pkg.sv
// Package for the three-level bitmap allocator: sizes, codes, payload types.
// Needs nothing else; used by the top level and its checker.
package hba3_pkg;

	localparam int FANOUT   = 16;
	localparam int DIG_W    = $clog2(FANOUT);
	localparam int ROW_W    = 2 * DIG_W;
	localparam int SLOT_W   = 3 * DIG_W;
	localparam int CNT_W    = SLOT_W + 1;
	localparam int CAPACITY = FANOUT * FANOUT * FANOUT;

	localparam logic [2:0] MODE_ALLOC   = 3'd0;
	localparam logic [2:0] MODE_FREE    = 3'd1;
	localparam logic [2:0] MODE_INIT    = 3'd2;
	localparam logic [2:0] MODE_REBUILD = 3'd3;
	localparam logic [2:0] MODE_SEARCH  = 3'd4;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_EMPTY  = 3'd1,
		ST_DOUBLE = 3'd2,
		ST_RANGE  = 3'd3,
		ST_NONE   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ALLOC_WR,
		S_FREE_WR,
		S_SWEEP,
		S_SEARCH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]        mode;
		logic [SLOT_W-1:0] entry_index;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		status_t           status;
	} rsp_t;

	// Index of the lowest set bit; zero for an empty word.
	function automatic logic [DIG_W-1:0] lowest_bit(input logic [FANOUT-1:0] w);
		logic [DIG_W-1:0] r;
		r = '0;
		for (int i = FANOUT - 1; i >= 0; i--) begin
			if (w[i]) begin
				r = DIG_W'(i);
			end
		end
		return r;
	endfunction

endpackage

FILE: sv/hierarchical_bitmap_allocator_3lvl.sv
// Top level of the three-level bitmap slot allocator.
// Depends on hba3_pkg for sizes, codes and the request and response types.
//
// The allocator hands out, returns and searches slots of a pool of up to 4096
// entries. Free slots are tracked in a leaf bitmap of 256 words of 16 bits, a
// middle map of 16 words and one top word; a set bit means something below is
// free. Alongside sits an in-use flag store of 256 rows of 16 flags. Both
// stores are memories with one write and one registered read per cycle each.
// After reset the block clears both stores, one row per cycle, with req_stall
// high; init clears the in-use rows the same way as part of its sweep. One
// transaction is worked on at a time and req_stall stays high meanwhile. For
// alloc and free, the accepting cycle picks the row (from the top and middle
// words for alloc, from the index for free) and starts its read; the write
// state then updates the row and writes it back (a double free writes
// nothing), and the done state loads the result into the output register.
// Init and rebuild sweep every leaf row at one row per cycle. A search reads
// one flag row per cycle from the row of its start index. The sweep and
// search lengths are set by the one-row-per-cycle memory port. The pool size
// register is written through count_we and count_wdata and is only to be
// changed while no transaction is in flight; values above 4096 act as 4096.
// A finished response waits in an output register until taken.
module hierarchical_bitmap_allocator_3lvl
	import hba3_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  logic             count_we,
	input  logic [CNT_W-1:0] count_wdata
);

	localparam logic [ROW_W-1:0] LAST_ROW = '1;

	state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic [SLOT_W-1:0] idx_q, idx_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic              init_q, init_d;
	logic [SLOT_W-1:0] res_slot_q, res_slot_d;
	status_t           res_status_q, res_status_d;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	logic              rsp_load;

	// Top and middle maps live in flip-flops.
	logic [FANOUT-1:0] top_q, top_d;
	logic [FANOUT-1:0] mid_q [FANOUT];
	logic              mid_we, mid_clr;
	logic [DIG_W-1:0]  mid_waddr;
	logic [FANOUT-1:0] mid_wdata;

	// Leaf map and in-use flags: memories cleared row by row.
	logic [FANOUT-1:0] leaf_mem [FANOUT*FANOUT];
	logic [FANOUT-1:0] use_mem  [FANOUT*FANOUT];
	logic [FANOUT-1:0] leaf_rd_q, use_rd_q;
	logic [ROW_W-1:0]  rd_addr;
	logic              leaf_we, use_we;
	logic [ROW_W-1:0]  leaf_waddr, use_waddr;
	logic [FANOUT-1:0] leaf_wdata, use_wdata;

	logic [CNT_W-1:0]  count_eff;
	logic [FANOUT-1:0] leaf_word, use_word;
	logic [FANOUT-1:0] row_mask, start_mask, word, mid_new, bit_c;
	logic [DIG_W-1:0]  dig_a, dig_b, dig_c;

	assign count_eff = (count_q > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : count_q;
	assign leaf_word = leaf_rd_q;
	assign use_word  = use_rd_q;

	// Slots of the current row that lie below the pool size.
	always_comb begin
		if ({1'b0, row_q} < count_eff[CNT_W-1:DIG_W]) begin
			row_mask = '1;
		end else if ({1'b0, row_q} == count_eff[CNT_W-1:DIG_W]) begin
			row_mask = ~({FANOUT{1'b1}} << count_eff[DIG_W-1:0]);
		end else begin
			row_mask = '0;
		end
	end

	// The first row of a search skips the slots below the start index.
	assign start_mask = (row_q == idx_q[SLOT_W-1:DIG_W]) ?
		({FANOUT{1'b1}} << idx_q[DIG_W-1:0]) : '1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			count_q      <= CNT_W'(CAPACITY);
			idx_q        <= '0;
			row_q        <= '0;
			init_q       <= 1'b0;
			res_slot_q   <= '0;
			res_status_q <= ST_OK;
			rsp_valid_q  <= 1'b0;
			top_q        <= '0;
			for (int i = 0; i < FANOUT; i++) begin
				mid_q[i] <= '0;
			end
		end else begin
			state_q      <= state_d;
			idx_q        <= idx_d;
			row_q        <= row_d;
			init_q       <= init_d;
			res_slot_q   <= res_slot_d;
			res_status_q <= res_status_d;
			top_q        <= top_d;
			if (count_we) begin
				count_q <= count_wdata;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (mid_clr) begin
				for (int i = 0; i < FANOUT; i++) begin
					mid_q[i] <= '0;
				end
			end else if (mid_we) begin
				mid_q[mid_waddr] <= mid_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= '{slot: res_slot_q, status: res_status_q};
		end
	end

	// Memories: one write and one registered read per cycle each.
	always_ff @(posedge clk) begin
		if (leaf_we) begin
			leaf_mem[leaf_waddr] <= leaf_wdata;
		end
		if (use_we) begin
			use_mem[use_waddr] <= use_wdata;
		end
		leaf_rd_q <= leaf_mem[rd_addr];
		use_rd_q  <= use_mem[rd_addr];
	end

	// Sequencer: next state, map updates and memory controls.
	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		row_d        = row_q;
		init_d       = init_q;
		res_slot_d   = res_slot_q;
		res_status_d = res_status_q;
		top_d        = top_q;
		rsp_load     = 1'b0;
		mid_we       = 1'b0;
		mid_clr      = 1'b0;
		mid_waddr    = row_q[ROW_W-1:DIG_W];
		mid_wdata    = '0;
		rd_addr      = row_q;
		leaf_we      = 1'b0;
		leaf_waddr   = row_q;
		leaf_wdata   = '0;
		use_we       = 1'b0;
		use_waddr    = row_q;
		use_wdata    = '0;
		dig_a        = lowest_bit(top_q);
		dig_b        = lowest_bit(mid_q[dig_a]);
		dig_c        = '0;
		word         = '0;
		mid_new      = '0;
		bit_c        = '0;
		req_stall    = 1'b1;

		unique case (state_q)
			S_CLEAR: begin
				// Both stores start empty: one row of each is zeroed per cycle.
				leaf_we = 1'b1;
				use_we  = 1'b1;
				row_d   = row_q + ROW_W'(1);
				if (row_q == LAST_ROW) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					idx_d        = req.entry_index;
					res_slot_d   = '0;
					res_status_d = ST_OK;
					state_d      = S_DONE;
					if (req.mode == MODE_ALLOC) begin
						if (top_q == '0) begin
							res_status_d = ST_EMPTY;
						end else begin
							row_d   = {dig_a, dig_b};
							rd_addr = {dig_a, dig_b};
							state_d = S_ALLOC_WR;
						end
					end else if (req.mode == MODE_FREE) begin
						if ({1'b0, req.entry_index} >= count_eff) begin
							res_status_d = ST_RANGE;
						end else begin
							row_d   = req.entry_index[SLOT_W-1:DIG_W];
							rd_addr = req.entry_index[SLOT_W-1:DIG_W];
							state_d = S_FREE_WR;
						end
					end else if (req.mode == MODE_INIT || req.mode == MODE_REBUILD) begin
						top_d    = '0;
						mid_clr  = 1'b1;
						init_d   = (req.mode == MODE_INIT);
						row_d    = '0;
						rd_addr  = '0;
						state_d  = S_SWEEP;
					end else if (req.mode == MODE_SEARCH) begin
						if ({1'b0, req.entry_index} >= count_eff) begin
							res_status_d = ST_NONE;
						end else begin
							row_d   = req.entry_index[SLOT_W-1:DIG_W];
							rd_addr = req.entry_index[SLOT_W-1:DIG_W];
							state_d = S_SEARCH;
						end
					end
				end
			end
			S_ALLOC_WR: begin
				dig_c      = lowest_bit(leaf_word);
				bit_c      = FANOUT'(1) << dig_c;
				word       = leaf_word & ~bit_c;
				leaf_we    = 1'b1;
				leaf_wdata = word;
				use_we     = 1'b1;
				use_wdata  = use_word | bit_c;
				mid_new    = mid_q[row_q[ROW_W-1:DIG_W]] & ~(FANOUT'(1) << row_q[DIG_W-1:0]);
				if (word == '0) begin
					mid_we    = 1'b1;
					mid_wdata = mid_new;
					if (mid_new == '0) begin
						top_d = top_q & ~(FANOUT'(1) << row_q[ROW_W-1:DIG_W]);
					end
				end
				res_slot_d   = {row_q, dig_c};
				res_status_d = ST_OK;
				state_d      = S_DONE;
			end
			S_FREE_WR: begin
				bit_c = FANOUT'(1) << idx_q[DIG_W-1:0];
				if ((use_word & bit_c) == '0 || (leaf_word & bit_c) != '0) begin
					res_status_d = ST_DOUBLE;
				end else begin
					leaf_we    = 1'b1;
					leaf_wdata = leaf_word | bit_c;
					use_we     = 1'b1;
					use_wdata  = use_word & ~bit_c;
					mid_we     = 1'b1;
					mid_wdata  = mid_q[row_q[ROW_W-1:DIG_W]] |
						(FANOUT'(1) << row_q[DIG_W-1:0]);
					top_d      = top_q | (FANOUT'(1) << row_q[ROW_W-1:DIG_W]);
				end
				state_d = S_DONE;
			end
			S_SWEEP: begin
				word       = row_mask & (init_q ? {FANOUT{1'b1}} : ~use_word);
				leaf_we    = 1'b1;
				leaf_wdata = word;
				// Init also drops every in-use flag; rebuild keeps them.
				use_we     = init_q;
				if (word != '0) begin
					mid_we    = 1'b1;
					mid_wdata = mid_q[row_q[ROW_W-1:DIG_W]] |
						(FANOUT'(1) << row_q[DIG_W-1:0]);
					top_d     = top_q | (FANOUT'(1) << row_q[ROW_W-1:DIG_W]);
				end
				if (row_q == LAST_ROW) begin
					state_d = S_DONE;
				end else begin
					row_d   = row_q + ROW_W'(1);
					rd_addr = row_q + ROW_W'(1);
				end
			end
			S_SEARCH: begin
				word = use_word & row_mask & start_mask;
				if (word != '0) begin
					res_slot_d   = {row_q, lowest_bit(word)};
					res_status_d = ST_OK;
					state_d      = S_DONE;
				end else if (row_q == LAST_ROW) begin
					res_status_d = ST_NONE;
					state_d      = S_DONE;
				end else begin
					row_d   = row_q + ROW_W'(1);
					rd_addr = row_q + ROW_W'(1);
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: sv/hba3_checker.sv
// Port-level checker for the three-level bitmap allocator, bound to the top.
// Depends on hba3_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hba3_checker
	import hba3_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input rsp_t rsp,
	input logic rsp_valid,
	input logic rsp_stall
);

	// A response that is held back keeps its contents.
	`ASSERT_CLK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "rsp changed while stalled")

	// Once a transaction is taken the block is busy on the next cycle.
	`ASSERT_CLK(a_busy_after_req, req_valid && !req_stall |=> req_stall, "second request taken while busy")

	// Only a successful alloc or search reports a slot number.
	`ASSERT_CLK(a_slot_zero, rsp_valid && rsp.status != ST_OK |-> rsp.slot == '0, "slot set on failure")

endmodule

bind hierarchical_bitmap_allocator_3lvl hba3_checker u_hba3_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp       (rsp),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall)
);

FILE: test/hierarchical_bitmap_allocator_3lvl_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the three-level bitmap slot allocator.
// Depends on hba3_pkg and hierarchical_bitmap_allocator_3lvl only.
module hierarchical_bitmap_allocator_3lvl_tb;
	import hba3_pkg::*;

	localparam logic [2:0] MODE_SPARE = 3'd5;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_stall;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_stall;
	rsp_t             rsp;
	logic             count_we;
	logic [CNT_W-1:0] count_wdata;

	hierarchical_bitmap_allocator_3lvl dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.count_we   (count_we),
		.count_wdata(count_wdata)
	);

	// Shadow copy of the allocator state, updated as each transaction is accepted.
	logic [FANOUT-1:0] shadow_top;
	logic [FANOUT-1:0] shadow_mid [FANOUT];
	logic [FANOUT-1:0] shadow_leaf [FANOUT*FANOUT];
	logic              shadow_used [CAPACITY];
	logic [CNT_W-1:0]  shadow_count;

	req_t pending_reqs [$];
	rsp_t awaited_rsps [$];
	int   error_count;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("hierarchical_bitmap_allocator_3lvl_tb: FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic int lowest_set(input logic [FANOUT-1:0] w);
		for (int i = 0; i < FANOUT; i++)
			if (w[i])
				return i;
		return 0;
	endfunction

	function automatic void shadow_clear_maps();
		shadow_top = '0;
		for (int i = 0; i < FANOUT; i++)
			shadow_mid[i] = '0;
		for (int i = 0; i < FANOUT*FANOUT; i++)
			shadow_leaf[i] = '0;
	endfunction

	function automatic void shadow_release(input int s);
		shadow_leaf[s / FANOUT][s % FANOUT] = 1'b1;
		shadow_mid[s / (FANOUT*FANOUT)][(s / FANOUT) % FANOUT] = 1'b1;
		shadow_top[s / (FANOUT*FANOUT)] = 1'b1;
	endfunction

	// Works out the response to one request and applies its effect on the shadow state.
	function automatic rsp_t allocator_outcome(input req_t r);
		rsp_t o;
		int   pool;
		int   a, b, c, s, idx;
		o.slot = '0;
		o.status = ST_OK;
		pool = (shadow_count > CAPACITY) ? CAPACITY : int'(shadow_count);
		idx = int'(r.entry_index);
		case (r.mode)
			MODE_ALLOC: begin
				if (shadow_top == '0) begin
					o.status = ST_EMPTY;
				end else begin
					a = lowest_set(shadow_top);
					b = lowest_set(shadow_mid[a]);
					c = lowest_set(shadow_leaf[a*FANOUT + b]);
					s = (a*FANOUT + b)*FANOUT + c;
					shadow_leaf[a*FANOUT + b][c] = 1'b0;
					if (shadow_leaf[a*FANOUT + b] == '0) begin
						shadow_mid[a][b] = 1'b0;
						if (shadow_mid[a] == '0)
							shadow_top[a] = 1'b0;
					end
					shadow_used[s] = 1'b1;
					o.slot = SLOT_W'(s);
				end
			end
			MODE_FREE: begin
				if (idx >= pool) begin
					o.status = ST_RANGE;
				end else if (!shadow_used[idx] || shadow_leaf[idx / FANOUT][idx % FANOUT]) begin
					o.status = ST_DOUBLE;
				end else begin
					shadow_release(idx);
					shadow_used[idx] = 1'b0;
				end
			end
			MODE_INIT: begin
				shadow_clear_maps();
				for (int i = 0; i < CAPACITY; i++)
					shadow_used[i] = 1'b0;
				for (int i = 0; i < pool; i++)
					shadow_release(i);
			end
			MODE_REBUILD: begin
				shadow_clear_maps();
				for (int i = 0; i < pool; i++)
					if (!shadow_used[i])
						shadow_release(i);
			end
			MODE_SEARCH: begin
				o.status = ST_NONE;
				for (int i = idx; i < pool; i++) begin
					if (shadow_used[i]) begin
						o.slot = SLOT_W'(i);
						o.status = ST_OK;
						break;
					end
				end
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	// Driver: presents queued requests at the falling edge after a random gap.
	// A request stays on the port until the rising edge that takes it.
	int send_gap;
	bit req_taken;
	initial send_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_taken) begin
				// Still waiting to be taken; the payload stays put.
			end else if (send_gap > 0) begin
				send_gap--;
				req_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				req <= pending_reqs.pop_front();
				req_valid <= 1'b1;
				send_gap = $urandom_range(0, 14);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Predicts the response of each request at the edge where it is taken.
	always @(posedge clk) begin
		req_taken <= arst_n && req_valid && !req_stall;
		if (arst_n && req_valid && !req_stall)
			awaited_rsps.push_back(allocator_outcome(req));
	end

	// Receiver stall: random wait per response, or a long hold when asked.
	// The long hold is counted down here, one cycle per falling edge.
	int stall_left;
	int hold_left;
	initial begin
		stall_left = 0;
		hold_left = 0;
	end
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
				if (rsp_valid && !rsp_stall)
					stall_left = $urandom_range(0, 1) ? 0 : $urandom_range(0, 14);
			end
		end
	end

	// Monitor: compares each response taken with the oldest prediction.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_rsps.size() == 0) begin
				report_mismatch("unexpected response, slot", int'(rsp.slot), -1);
			end else begin
				want = awaited_rsps.pop_front();
				if (rsp.slot !== want.slot)
					report_mismatch("slot", int'(rsp.slot), int'(want.slot));
				if (rsp.status !== want.status)
					report_mismatch("status", int'(rsp.status), int'(want.status));
			end
		end
	end

	function automatic req_t make_req(input logic [2:0] m, input int idx);
		req_t r;
		r.mode = m;
		r.entry_index = SLOT_W'(idx);
		return r;
	endfunction

	task automatic drain();
		while (pending_reqs.size() > 0 || req_valid || awaited_rsps.size() > 0)
			@(posedge clk);
		// Every mode gives a response, so a short settle is enough.
		repeat (10) @(posedge clk);
	endtask

	task automatic set_pool_size(input int n);
		@(negedge clk);
		count_we <= 1'b1;
		count_wdata <= CNT_W'(n);
		@(negedge clk);
		count_we <= 1'b0;
		shadow_count = CNT_W'(n);
	endtask

	// One random phase: mostly allocs and frees of indices within or just above
	// the pool, with occasional sweeps, searches and unused modes, all indices kept mostly near the pool.
	task automatic random_phase(input int n, input int pool);
		int pick, span;
		span = (pool == 0) ? 1 : pool;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				pending_reqs.push_back(make_req(MODE_ALLOC, $urandom));
			else if (pick < 80)
				pending_reqs.push_back(make_req(MODE_FREE,
					($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, span + 2)));
			else if (pick < 92)
				pending_reqs.push_back(make_req(MODE_SEARCH,
					($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, span)));
			else if (pick < 95)
				pending_reqs.push_back(make_req(MODE_REBUILD, $urandom));
			else if (pick < 97)
				pending_reqs.push_back(make_req(MODE_INIT, $urandom));
			else
				pending_reqs.push_back(make_req(3'($urandom_range(5, 7)), $urandom));
		end
	endtask

	initial begin
		int sizes [6];
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		count_we = 1'b0;
		count_wdata = '0;
		error_count = 0;
		shadow_clear_maps();
		for (int i = 0; i < CAPACITY; i++)
			shadow_used[i] = 1'b0;
		shadow_count = CNT_W'(CAPACITY);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: empty pool, double-free errors, search misses, unused modes,
		// then a small pool with range errors, then the full index range.
		pending_reqs.push_back(make_req(MODE_ALLOC, 0));
		pending_reqs.push_back(make_req(MODE_FREE, 4095));
		pending_reqs.push_back(make_req(MODE_FREE, 0));
		pending_reqs.push_back(make_req(MODE_SEARCH, 0));
		pending_reqs.push_back(make_req(MODE_SEARCH, 4095));
		pending_reqs.push_back(make_req(3'd7, 4095));
		pending_reqs.push_back(make_req(MODE_SPARE, 0));
		drain();
		set_pool_size(3);
		pending_reqs.push_back(make_req(MODE_INIT, 0));
		for (int i = 0; i < 4; i++)
			pending_reqs.push_back(make_req(MODE_ALLOC, 0));
		pending_reqs.push_back(make_req(MODE_FREE, 3));
		pending_reqs.push_back(make_req(MODE_FREE, 1));
		pending_reqs.push_back(make_req(MODE_FREE, 1));
		pending_reqs.push_back(make_req(MODE_SEARCH, 1));
		pending_reqs.push_back(make_req(MODE_REBUILD, 0));
		pending_reqs.push_back(make_req(MODE_ALLOC, 0));
		pending_reqs.push_back(make_req(MODE_SEARCH, 2));
		drain();
		// Count shrunk without init: allocs may still hand out slots above it.
		set_pool_size(1);
		pending_reqs.push_back(make_req(MODE_ALLOC, 0));
		pending_reqs.push_back(make_req(MODE_ALLOC, 0));
		pending_reqs.push_back(make_req(MODE_FREE, 2));
		drain();
		set_pool_size(8191);
		pending_reqs.push_back(make_req(MODE_INIT, 0));
		pending_reqs.push_back(make_req(MODE_FREE, 4095));
		pending_reqs.push_back(make_req(MODE_SEARCH, 4095));
		drain();

		// Random phases across pool sizes, the extremes among them.
		sizes = '{0, 1, 17, 300, 4096, 8191};
		foreach (sizes[k]) begin
			set_pool_size(sizes[k]);
			pending_reqs.push_back(make_req(MODE_INIT, 0));
			random_phase(280, (sizes[k] > CAPACITY) ? CAPACITY : sizes[k]);
			if (k == 2) begin
				// Long receiver hold-off while requests keep coming.
				hold_left = 400;
			end
			drain();
		end

		repeat (300) @(posedge clk);
		if (error_count == 0 && awaited_rsps.size() == 0)
			$display("hierarchical_bitmap_allocator_3lvl_tb: PASS");
		else
			$display("hierarchical_bitmap_allocator_3lvl_tb: FAIL");
		$finish;
	end

endmodule
